>>> rtl/stirs_pkg.sv
// ----------------------------------------------------------------------------
// stirs_pkg: shared types for the sorted table block
// Item structs, result codes and the controller state encoding.
// ----------------------------------------------------------------------------
package stirs_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } stirs_in_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] fill_count;
  } stirs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_FIN,
    ST_SR_RD,
    ST_SR_CMP
  } stirs_state_t;

endpackage

>>> rtl/stirs_ram.sv
// ----------------------------------------------------------------------------
// stirs_ram: table storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module stirs_ram
  import stirs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sorted_table_insert_and_rank_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_and_rank_search_top: ordered table with rank search
// Keeps up to CAPACITY signed values in ascending order in one memory.
// ----------------------------------------------------------------------------
// Usage
//   An item is taken at a rising edge where start is high and busy is low.
//   A mode of insert places the value ahead of the first stored value that
//   is not smaller, so a new value goes ahead of any equal values already
//   stored. A mode of search reports whether the value is stored and how
//   many stored values are at or below it. Every item gives exactly one
//   result, shown on out_item for a single cycle while out_valid is high.
//   The receiver cannot stall, so the result must be captured in that cycle.
//   An insert walks down from the top of the table and a search walks up
//   from the bottom; each visited entry takes a read state and a compare
//   state on the single table memory, and an insert also writes the entry
//   it moves up one place. An insert into a full table, and any item on an
//   empty table, is answered straight from idle without a walk.
//   For a walk, busy stays high from the accept until the result strobe;
//   an item answered straight from idle leaves busy low.
//   Reset clears the fill count and the controller; the table contents are
//   left as they are and only written entries are ever read.
//   position and fill_count are reported as their low seven bits.
// ----------------------------------------------------------------------------
module sorted_table_insert_and_rank_search_top
  import stirs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  stirs_in_t  in_item,
  output logic       out_valid,
  output stirs_out_t out_item
);

  // Address width covers the table; count width can also hold CAPACITY.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  stirs_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  // Walk index: shift target on insert, scan position on search.
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  stirs_in_t     item_r, item_nxt;
  logic          out_valid_r, out_valid_nxt;
  stirs_out_t    out_r, out_nxt;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic signed [VALUE_W-1:0] mem_rdata;

  logic accept;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] cnt_inc;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign idx_inc   = idx_r + CW'(1);
  assign cnt_inc   = cnt_r + CW'(1);

  stirs_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers need no reset.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    item_r  <= item_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_wdata     = item_r.value;
    mem_raddr     = idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_item;
          found_nxt = 1'b0;
          if (in_item.mode == MODE_INSERT) begin
            if (cnt_r >= CW'(CAPACITY)) begin
              // Full table: drop the value and report it right away.
              out_valid_nxt      = 1'b1;
              out_nxt.status     = STATUS_FULL;
              out_nxt.found      = 1'b0;
              out_nxt.position   = '0;
              out_nxt.fill_count = POS_W'(cnt_r);
            end else if (cnt_r == '0) begin
              // Empty table: the value becomes the first entry.
              mem_we             = 1'b1;
              mem_waddr          = '0;
              mem_wdata          = in_item.value;
              cnt_nxt            = CW'(1);
              out_valid_nxt      = 1'b1;
              out_nxt.status     = STATUS_DONE;
              out_nxt.found      = 1'b0;
              out_nxt.position   = '0;
              out_nxt.fill_count = POS_W'(CW'(1));
            end else begin
              // Walk down from the top, moving larger-or-equal entries up.
              idx_nxt   = cnt_r;
              state_nxt = ST_INS_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              out_valid_nxt      = 1'b1;
              out_nxt.status     = STATUS_DONE;
              out_nxt.found      = 1'b0;
              out_nxt.position   = '0;
              out_nxt.fill_count = '0;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_SR_RD;
            end
          end
        end
      end

      ST_INS_RD: begin
        mem_raddr = AW'(idx_r - CW'(1));
        state_nxt = ST_INS_CMP;
      end

      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata >= item_r.value) begin
          // Entry below the hole is not smaller: move it up one place.
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r - CW'(1);
          if (idx_r == CW'(1)) begin
            state_nxt = ST_INS_FIN;
          end else begin
            state_nxt = ST_INS_RD;
          end
        end else begin
          mem_wdata          = item_r.value;
          cnt_nxt            = cnt_inc;
          out_valid_nxt      = 1'b1;
          out_nxt.status     = STATUS_DONE;
          out_nxt.found      = 1'b0;
          out_nxt.position   = '0;
          out_nxt.fill_count = POS_W'(cnt_inc);
          state_nxt          = ST_IDLE;
        end
      end

      ST_INS_FIN: begin
        // Every entry moved up; the value goes to the bottom slot.
        mem_we             = 1'b1;
        mem_wdata          = item_r.value;
        cnt_nxt            = cnt_inc;
        out_valid_nxt      = 1'b1;
        out_nxt.status     = STATUS_DONE;
        out_nxt.found      = 1'b0;
        out_nxt.position   = '0;
        out_nxt.fill_count = POS_W'(cnt_inc);
        state_nxt          = ST_IDLE;
      end

      ST_SR_RD: begin
        state_nxt = ST_SR_CMP;
      end

      ST_SR_CMP: begin
        out_nxt.status     = STATUS_DONE;
        out_nxt.fill_count = POS_W'(cnt_r);
        if (mem_rdata <= item_r.value) begin
          found_nxt = found_r || (mem_rdata == item_r.value);
          idx_nxt   = idx_inc;
          if (idx_inc == cnt_r) begin
            out_valid_nxt    = 1'b1;
            out_nxt.found    = found_nxt;
            out_nxt.position = POS_W'(idx_inc);
            state_nxt        = ST_IDLE;
          end else begin
            state_nxt = ST_SR_RD;
          end
        end else begin
          // First larger entry ends the scan.
          out_valid_nxt    = 1'b1;
          out_nxt.found    = found_r;
          out_nxt.position = POS_W'(idx_r);
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A result strobe only appears while the controller is idle.
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while controller busy");

  // The fill count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // A completed insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (item_r.mode == MODE_INSERT) && (out_r.status == STATUS_DONE))
    |-> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not grow the table by one");

  // The insert walk stays inside the filled part of the table.
  a_ins_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_INS_RD) || (state_r == ST_INS_CMP))
    |-> ((idx_r != '0) && (idx_r <= cnt_r)))
    else $error("insert walk index out of range");

  // The search scan only reads written entries.
  a_sr_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SR_RD) || (state_r == ST_SR_CMP)) |-> (idx_r < cnt_r))
    else $error("search index out of range");

endmodule

>>> verif/tb_sorted_table_insert_and_rank_search_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_and_rank_search_top: self-checking bench
// Drives insert and search items into the sorted table with random gaps.
// A scoreboard keeps its own ordered copy of the table, works out every
// result at the accept edge and compares it field by field with the strobed
// result.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_and_rank_search_top;
  import stirs_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int RAND_ITEMS = 1030;
  // The slowest item walks the whole table; allow some slack on top of that.
  localparam int DRAIN      = 2 * CAPACITY + 8;
  // The watchdog limit is several times what the whole run needs at worst.
  localparam int LIMIT      = 1000000;
  localparam int MAX_REPORTS = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: an ordered shadow of the table plus the results still owed.
  // --------------------------------------------------------------------------
  class rank_scoreboard;
    int         sorted_vals[CAPACITY];
    int         fill;
    stirs_out_t owed_q[$];
    int         errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // Called at the edge where an item is taken; updates the shadow table
    // and queues the result that item must produce.
    function void note_item(stirs_in_t item);
      stirs_out_t res;
      int         v;
      int         k;
      res = '0;
      v   = item.value;
      k   = 0;
      if (item.mode == MODE_INSERT) begin
        if (fill >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          // Stop at the first stored value that is not smaller.
          while (k < fill && sorted_vals[k] < v) k++;
          for (int j = fill; j > k; j--) sorted_vals[j] = sorted_vals[j-1];
          sorted_vals[k] = v;
          fill++;
        end
      end else begin
        res.status = STATUS_DONE;
        while (k < fill && sorted_vals[k] <= v) begin
          if (sorted_vals[k] == v) res.found = 1'b1;
          k++;
        end
        res.position = POS_W'(k);
      end
      res.fill_count = POS_W'(fill);
      owed_q.push_back(res);
    endfunction

    function void check_result(stirs_out_t got);
      stirs_out_t exp;
      if (owed_q.size() == 0) begin
        flag($sformatf({"result with none owed: status=%0d found=%0d ",
                        "position=%0d fill_count=%0d"},
                       got.status, got.found, got.position, got.fill_count));
        return;
      end
      exp = owed_q.pop_front();
      if (got.status !== exp.status || got.found !== exp.found ||
          got.position !== exp.position || got.fill_count !== exp.fill_count) begin
        flag($sformatf({"mismatch: expected status=%0d found=%0d position=%0d ",
                        "fill_count=%0d, got status=%0d found=%0d position=%0d fill_count=%0d"},
                       exp.status, exp.found, exp.position, exp.fill_count,
                       got.status, got.found, got.position, got.fill_count));
      end
    endfunction

    function void close_out();
      if (owed_q.size() != 0) flag($sformatf("%0d results never arrived", owed_q.size()));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  stirs_in_t  in_item;
  logic       out_valid;
  stirs_out_t out_item;

  rank_scoreboard sb = new();
  int calm_left = 0;

  sorted_table_insert_and_rank_search_top #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // 2 ns clock, one delay for each half.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Monitor. Everything is sampled at the rising edge, before the block's own
  // updates for that edge land. A result at this edge always belongs to an
  // item taken at an earlier edge, so it is checked before the new item is
  // noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_item(in_item);
    end
  end

  function automatic stirs_in_t mk_item(logic mode, int value);
    stirs_in_t item;
    item.mode  = mode;
    item.value = value;
    return item;
  endfunction

  // Gap before the next item: mostly none or short, now and then long, and
  // occasionally a calm stretch with no gaps at all.
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Values lean toward stored values and their neighbors, so searches hit and
  // inserts pile up duplicates; else extremes, values near zero or any 32 bits.
  function automatic int pick_value();
    int sel;
    int idx;
    sel = $urandom_range(0, 99);
    if (sb.fill > 0 && sel < 45) begin
      idx = $urandom_range(0, sb.fill - 1);
      if (sel < 30) return sb.sorted_vals[idx];
      return sb.sorted_vals[idx] + ($urandom_range(0, 1) ? 1 : -1);
    end
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: ;
    endcase
    if (sel < 65) return int'($urandom_range(0, 15)) - 8;
    return $urandom;
  endfunction

  // Presents one item from a falling edge and holds it until the block takes
  // it. start stays high across back-to-back items; a gap drops it first.
  task automatic send_item(stirs_in_t item, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Watchdog for a hung block or a lost result.
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("sorted_table_insert_and_rank_search_top test failed");
    $finish;
  end

  initial begin
    stirs_in_t directed_q[$];
    logic      mode;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items: searches on an empty table, inserts at both ends of the
    // signed range and around zero, duplicates, then hits and misses at the
    // ends and in the middle of the table.
    directed_q = '{
      mk_item(MODE_SEARCH, 0),
      mk_item(MODE_SEARCH, 32'h8000_0000),
      mk_item(MODE_INSERT, 0),
      mk_item(MODE_INSERT, 32'h7FFF_FFFF),
      mk_item(MODE_INSERT, 32'h8000_0000),
      mk_item(MODE_INSERT, -1),
      mk_item(MODE_INSERT, 1),
      mk_item(MODE_INSERT, 0),
      mk_item(MODE_INSERT, 0),
      mk_item(MODE_INSERT, 32'h7FFF_FFFF),
      mk_item(MODE_INSERT, 32'h8000_0000),
      mk_item(MODE_SEARCH, 0),
      mk_item(MODE_SEARCH, 32'h8000_0000),
      mk_item(MODE_SEARCH, 32'h8000_0001),
      mk_item(MODE_SEARCH, 32'h7FFF_FFFF),
      mk_item(MODE_SEARCH, 32'h7FFF_FFFE),
      mk_item(MODE_SEARCH, 5),
      mk_item(MODE_SEARCH, -5),
      mk_item(MODE_SEARCH, -1),
      mk_item(MODE_INSERT, 32'h5555_AAAA),
      mk_item(MODE_SEARCH, 32'hAAAA_5555)
    };
    foreach (directed_q[i]) send_item(directed_q[i], (i % 4 == 3) ? 2 : 0);

    // Random items. Inserts are a minority so that the table fills at an
    // even pace and searches see every fill level; once it is full, the
    // remaining inserts exercise the drop path while searches continue.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      mode = ($urandom_range(0, 99) < ((sb.fill < CAPACITY) ? 15 : 10)) ?
             MODE_INSERT : MODE_SEARCH;
      send_item(mk_item(mode, pick_value()), next_gap());
    end

    @(negedge clk);
    start <= 1'b0;

    // Let every owed result arrive, then give the block time to show any
    // stray strobe.
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    sb.close_out();
    if (sb.errors == 0) begin
      $display("sorted_table_insert_and_rank_search_top test passed");
    end else begin
      $display("sorted_table_insert_and_rank_search_top test failed");
    end
    $finish;
  end

endmodule
